FILE: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // Field widths
    localparam int CH_W  = 8;
    localparam int SUM_W = 9;
    localparam int HUE_W = 15;

    // Fixed-point scales
    localparam int FULL_SCALE        = 255;
    localparam int HUE_STEPS_PER_DEG = 64;
    localparam int HUE_SECTOR_SCALE  = 60 * HUE_STEPS_PER_DEG;

    // Hue is forced to zero when 120*range < 255, i.e. range below this
    localparam int GREY_RNG_LIMIT = 3;

    // Sector offsets in 1/64 degree
    localparam logic [HUE_W-1:0] HUE_BASE_0   = HUE_W'(0);
    localparam logic [HUE_W-1:0] HUE_BASE_120 = HUE_W'(120 * HUE_STEPS_PER_DEG);
    localparam logic [HUE_W-1:0] HUE_BASE_240 = HUE_W'(240 * HUE_STEPS_PER_DEG);
    localparam logic [HUE_W-1:0] HUE_BASE_360 = HUE_W'(360 * HUE_STEPS_PER_DEG);

    // Divider geometry: hue quotient reaches 3840, so 12 quotient bits
    localparam int DIV_QUOT_W = 12;
    localparam int HUE_DVD_W  = 20;
    localparam int SAT_DVD_W  = 16;

    // Pipeline: front end, operand prep, divider stages, output register
    localparam int DIV_FIRST  = 2;
    localparam int NUM_STAGES = DIV_QUOT_W + 3;

    // Side data carried alongside the dividers
    typedef struct packed {
        logic [CH_W-1:0]  value;
        logic [SUM_W-1:0] sum;
        logic [HUE_W-1:0] base;
        logic             neg;
        logic             grey;
        logic             mx_zero;
        logic             rng_zero;
    } side_t;

endpackage

FILE: rtl/core/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The quotient must fit in QUOT_W bits; a zero divisor gives a junk result.
module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int DVD_W  = HUE_DVD_W,
    parameter int DVS_W  = CH_W,
    parameter int QUOT_W = DIV_QUOT_W
) (
    input  logic              aclk,
    input  logic [QUOT_W-1:0] en,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic [QUOT_W-1:0] quotient
);

    localparam int WORK_W = (DVD_W > DVS_W + QUOT_W - 1) ? DVD_W : DVS_W + QUOT_W - 1;

    logic [WORK_W-1:0] rem_reg [QUOT_W-1];
    logic [DVS_W-1:0]  dvs_reg [QUOT_W-1];
    logic [QUOT_W-1:0] quo_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic [WORK_W-1:0] rem_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [QUOT_W-1:0] quo_in;
        logic [WORK_W-1:0] trial;
        logic              fits;
        logic [QUOT_W-1:0] quo_next;

        // Select stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign rem_in = WORK_W'(dividend);
            assign dvs_in = divisor;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Try subtracting the divisor aligned to this quotient bit
        assign trial    = WORK_W'(dvs_in) << (QUOT_W - 1 - k);
        assign fits     = (rem_in >= trial);
        assign quo_next = quo_in | (fits ? (QUOT_W'(1) << (QUOT_W - 1 - k)) : '0);

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                quo_reg[k] <= quo_next;
            end
        end

        // Last stage keeps only the quotient
        if (k < QUOT_W - 1) begin : g_keep
            logic [WORK_W-1:0] rem_next;

            assign rem_next = fits ? (rem_in - trial) : rem_in;

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= rem_next;
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    end

    assign quotient = quo_reg[QUOT_W-1];

endmodule

FILE: rtl/core/rgb_to_hsv_hsl_converter.sv
// RGB to HSV/HSL pixel converter. Takes one 8-bit RGB pixel per clock
// while s_ready is high and returns hue (1/64 degree, floored), HSV value
// and saturation, and HSL lightness (as max+min) and saturation, all
// scaled so 255 means 1.0. The pipeline is the 12-stage restoring dividers
// (one quotient bit per stage) plus a front-end compare stage, an operand
// stage and the output register. Each stage advances whenever its
// successor can take its data, so bubbles close up and the input keeps
// accepting while a result waits on m_ready until every stage is full.
// No state is kept between pixels.
module rgb_to_hsv_hsl_converter
    import rgbhsv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CH_W-1:0]  s_red,
    input  logic [CH_W-1:0]  s_green,
    input  logic [CH_W-1:0]  s_blue,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [HUE_W-1:0] m_hue,
    output logic [CH_W-1:0]  m_value,
    output logic [CH_W-1:0]  m_hsv_saturation,
    output logic [SUM_W-1:0] m_lightness_x2,
    output logic [CH_W-1:0]  m_hsl_saturation
);

    localparam int LAST = NUM_STAGES - 1;

    // ------------------------------------------------------------------
    // Pipeline control: valid per stage, advance when downstream frees up
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[LAST] = !valid_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[LAST];

    // ------------------------------------------------------------------
    // Stage 0: max, min, hue sector and signed channel difference
    // ------------------------------------------------------------------
    logic [CH_W-1:0]        s0_mx_next, s0_mn_next;
    logic [HUE_W-1:0]       s0_base_next;
    logic signed [CH_W:0]   s0_d_next;
    logic [CH_W-1:0]        s0_mx_reg, s0_mn_reg;
    logic [HUE_W-1:0]       s0_base_reg;
    logic signed [CH_W:0]   s0_d_reg;
    logic signed [CH_W:0]   r_s, g_s, b_s;

    assign r_s = $signed({1'b0, s_red});
    assign g_s = $signed({1'b0, s_green});
    assign b_s = $signed({1'b0, s_blue});

    always_comb begin
        s0_mx_next = s_red;
        if (s_green > s0_mx_next) s0_mx_next = s_green;
        if (s_blue > s0_mx_next)  s0_mx_next = s_blue;
        s0_mn_next = s_red;
        if (s_green < s0_mn_next) s0_mn_next = s_green;
        if (s_blue < s0_mn_next)  s0_mn_next = s_blue;

        // Pick sector in priority order
        if (s_green >= s_blue && s_red >= s_green) begin
            s0_base_next = HUE_BASE_0;
            s0_d_next    = g_s - b_s;
        end else if (s_green < s_blue && s_red >= s_blue) begin
            s0_base_next = HUE_BASE_360;
            s0_d_next    = g_s - b_s;
        end else if (s_green >= s_blue && s_green >= s_red) begin
            s0_base_next = HUE_BASE_120;
            s0_d_next    = b_s - r_s;
        end else begin
            s0_base_next = HUE_BASE_240;
            s0_d_next    = r_s - g_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_mx_reg   <= s0_mx_next;
            s0_mn_reg   <= s0_mn_next;
            s0_base_reg <= s0_base_next;
            s0_d_reg    <= s0_d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: range, sum, dividends and divisors, special-case flags
    // ------------------------------------------------------------------
    logic [CH_W-1:0]      rng;
    logic [SUM_W-1:0]     sum;
    logic                 neg;
    logic [CH_W-1:0]      mag;
    logic [SUM_W-1:0]     sum_flip;
    logic [HUE_DVD_W-1:0] s1_hue_dvd_next, s1_hue_dvd_reg;
    logic [SAT_DVD_W-1:0] s1_sat_dvd_next, s1_sat_dvd_reg;
    logic [CH_W-1:0]      s1_hsl_den_next, s1_hsl_den_reg;
    logic [CH_W-1:0]      s1_rng_reg;
    side_t                s1_side_next, s1_side_reg;

    assign rng      = s0_mx_reg - s0_mn_reg;
    assign sum      = SUM_W'(s0_mx_reg) + SUM_W'(s0_mn_reg);
    assign neg      = s0_d_reg[CH_W];
    assign mag      = neg ? CH_W'(-s0_d_reg) : s0_d_reg[CH_W-1:0];
    assign sum_flip = SUM_W'(2 * FULL_SCALE) - sum;

    always_comb begin
        // Negative difference rounds toward minus infinity: bias by rng-1
        s1_hue_dvd_next = HUE_DVD_W'(mag) * HUE_DVD_W'(HUE_SECTOR_SCALE);
        if (neg) begin
            s1_hue_dvd_next = s1_hue_dvd_next + HUE_DVD_W'(rng) - HUE_DVD_W'(1);
        end
        s1_sat_dvd_next = SAT_DVD_W'(rng) * SAT_DVD_W'(FULL_SCALE);
        s1_hsl_den_next = (sum > SUM_W'(FULL_SCALE)) ? sum_flip[CH_W-1:0] : sum[CH_W-1:0];

        s1_side_next.value    = s0_mx_reg;
        s1_side_next.sum      = sum;
        s1_side_next.base     = s0_base_reg;
        s1_side_next.neg      = neg;
        s1_side_next.grey     = (rng < CH_W'(GREY_RNG_LIMIT));
        s1_side_next.mx_zero  = (s0_mx_reg == '0);
        s1_side_next.rng_zero = (rng == '0);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_hue_dvd_reg <= s1_hue_dvd_next;
            s1_sat_dvd_reg <= s1_sat_dvd_next;
            s1_hsl_den_reg <= s1_hsl_den_next;
            s1_rng_reg     <= rng;
            s1_side_reg    <= s1_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: three dividers in lockstep, side data alongside
    // ------------------------------------------------------------------
    logic [DIV_QUOT_W-1:0] div_en;
    logic [DIV_QUOT_W-1:0] hue_q, hsv_q, hsl_q;
    side_t                 side_reg [DIV_QUOT_W];

    assign div_en = stage_en[DIV_FIRST +: DIV_QUOT_W];

    rgbhsv_div #(
        .DVD_W  (HUE_DVD_W),
        .DVS_W  (CH_W),
        .QUOT_W (DIV_QUOT_W)
    ) u_hue_div (
        .aclk     (aclk),
        .en       (div_en),
        .dividend (s1_hue_dvd_reg),
        .divisor  (s1_rng_reg),
        .quotient (hue_q)
    );

    rgbhsv_div #(
        .DVD_W  (SAT_DVD_W),
        .DVS_W  (CH_W),
        .QUOT_W (DIV_QUOT_W)
    ) u_hsv_div (
        .aclk     (aclk),
        .en       (div_en),
        .dividend (s1_sat_dvd_reg),
        .divisor  (s1_side_reg.value),
        .quotient (hsv_q)
    );

    rgbhsv_div #(
        .DVD_W  (SAT_DVD_W),
        .DVS_W  (CH_W),
        .QUOT_W (DIV_QUOT_W)
    ) u_hsl_div (
        .aclk     (aclk),
        .en       (div_en),
        .dividend (s1_sat_dvd_reg),
        .divisor  (s1_hsl_den_reg),
        .quotient (hsl_q)
    );

    always_ff @(posedge aclk) begin
        if (div_en[0]) begin
            side_reg[0] <= s1_side_reg;
        end
        for (int k = 1; k < DIV_QUOT_W; k++) begin
            if (div_en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply sector offset and special cases
    // ------------------------------------------------------------------
    side_t            side_out;
    logic [HUE_W-1:0] hue_next;
    logic [HUE_W-1:0] hue_reg;
    logic [CH_W-1:0]  value_reg, hsv_sat_reg, hsl_sat_reg;
    logic [SUM_W-1:0] light_reg;

    assign side_out = side_reg[DIV_QUOT_W-1];

    always_comb begin
        if (side_out.grey) begin
            hue_next = '0;
        end else if (side_out.neg) begin
            hue_next = side_out.base - HUE_W'(hue_q);
        end else begin
            hue_next = side_out.base + HUE_W'(hue_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[LAST]) begin
            hue_reg     <= hue_next;
            value_reg   <= side_out.value;
            light_reg   <= side_out.sum;
            hsv_sat_reg <= side_out.mx_zero ? '0 : hsv_q[CH_W-1:0];
            hsl_sat_reg <= side_out.rng_zero ? '0 : hsl_q[CH_W-1:0];
        end
    end

    assign m_hue            = hue_reg;
    assign m_value          = value_reg;
    assign m_hsv_saturation = hsv_sat_reg;
    assign m_lightness_x2   = light_reg;
    assign m_hsl_saturation = hsl_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input backpressure only when every stage holds a pixel
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A colored hue implies both saturations are nonzero
    a_hue_needs_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hue != '0) |-> (m_hsv_saturation != '0 && m_hsl_saturation != '0))
        else $error("nonzero hue with zero saturation");

    // Hue stays below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue < HUE_BASE_360))
        else $error("hue out of range");

    // Lightness sum lies between value and twice value
    a_light_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lightness_x2 >= SUM_W'(m_value)
                     && m_lightness_x2 <= (SUM_W'(m_value) << 1)))
        else $error("lightness inconsistent with value");

endmodule
